@@ rtl/ffsd_pkg.sv @@
// Shared types, codes and constants for the farbfeld stream decoder.
package ffsd_pkg;

  localparam int unsigned DIM_BITS_DEF = 32;
  localparam int unsigned DIM_W        = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned TDATA_W      = 4 * BYTE_W + 2 * DIM_W;
  localparam int unsigned TUSER_W      = 3;

  localparam logic [BYTE_W-1:0] SIG_TEXT [0:7] = '{
    8'h66, 8'h61, 8'h72, 8'h62, 8'h66, 8'h65, 8'h6C, 8'h64
  };

  typedef enum logic [1:0] {
    PH_SIG  = 2'd0,
    PH_DIMS = 2'd1,
    PH_PIX  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_BADSIG = 2'd2
  } kind_e;

  localparam logic [2:0] LAST_IDX = 3'd7;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              row_end;
    logic              image_end;
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
  } result_t;

endpackage

@@ rtl/farbfeld_stream_decoder_core.sv @@
// Output: a result is registered and appears on the master side in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the input stalls only while a held result is not taken.
// Results: one per signature group (on mismatch), one per header, one per eight pixel bytes.
// Reset: asynchronous active low; returns to the signature search with the output empty.
// Top level of the farbfeld stream decoder with its output register.
module farbfeld_stream_decoder_core #(
  parameter int unsigned DIM_BITS = ffsd_pkg::DIM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ffsd_pkg::BYTE_W-1:0]  s_axis_tdata,  // in_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red, green, blue, alpha, image_width, image_height
  output logic [ffsd_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [ffsd_pkg::TUSER_W-1:0] m_axis_tuser,  // kind, row_end
  output logic                         m_axis_tlast   // image_end
);
  import ffsd_pkg::*;

  logic    accept;
  result_t res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ffsd_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.image_height, out_q.image_width,
                          out_q.alpha, out_q.blue, out_q.green, out_q.red};
  assign m_axis_tuser  = {out_q.row_end, out_q.kind};
  assign m_axis_tlast  = out_q.image_end;

`ifndef SYNTH
  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  a_badsig_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.kind == KIND_BADSIG) |->
      (m_axis_tdata == '0 && !out_q.row_end && !out_q.image_end))
    else $error("bad signature result carries payload");

  a_header_no_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.kind == KIND_HEADER) |-> !out_q.row_end)
    else $error("header result marked as row end");

  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.kind == KIND_PIXEL && out_q.image_end) |-> out_q.row_end)
    else $error("image end without row end");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.kind == KIND_PIXEL || out_q.kind == KIND_HEADER ||
                       out_q.kind == KIND_BADSIG))
    else $error("result with an unused kind code");
`endif

endmodule

@@ rtl/ffsd_parser.sv @@
// Header and pixel parser: signature check, dimension capture and pixel assembly.
module ffsd_parser #(
  parameter int unsigned DIM_BITS = ffsd_pkg::DIM_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [ffsd_pkg::BYTE_W-1:0] byte_i,
  output ffsd_pkg::result_t          res_o
);
  import ffsd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [2:0]          idx_q, idx_d;
  logic                match_q, match_d;
  logic [55:0]         dims_q, dims_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [BYTE_W-1:0]   red_q, red_d;
  logic [BYTE_W-1:0]   green_q, green_d;
  logic [BYTE_W-1:0]   blue_q, blue_d;
  logic [BYTE_W-1:0]   alpha_q, alpha_d;

  logic [63:0]         dims_full;
  logic [DIM_BITS-1:0] w_new, h_new;
  logic                col_last, row_last;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'((64'(1) << DIM_BITS) - 64'(1));
    return (v > lim) ? lim[DIM_BITS-1:0] : v[DIM_BITS-1:0];
  endfunction

  assign dims_full = {dims_q, byte_i};
  assign w_new     = clamp_dim(dims_full[63:32]);
  assign h_new     = clamp_dim(dims_full[31:0]);
  assign col_last  = ({1'b0, col_q} + (DIM_BITS+1)'(1)) >= {1'b0, width_q};
  assign row_last  = ({1'b0, row_q} + (DIM_BITS+1)'(1)) >= {1'b0, height_q};

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    match_d  = match_q;
    dims_d   = dims_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    alpha_d  = alpha_q;
    res_o    = '0;
    case (phase_q)
      PH_DIMS: begin
        dims_d = dims_full[55:0];
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + 3'd1;
        end else begin
          width_d            = w_new;
          height_d           = h_new;
          col_d              = '0;
          row_d              = '0;
          idx_d              = '0;
          res_o.valid        = 1'b1;
          res_o.kind         = KIND_HEADER;
          res_o.image_width  = DIM_W'(w_new);
          res_o.image_height = DIM_W'(h_new);
          if (w_new == '0 || h_new == '0) begin
            res_o.image_end = 1'b1;
            phase_d         = PH_SIG;
            match_d         = 1'b1;
          end else begin
            phase_d = PH_PIX;
          end
        end
      end
      PH_PIX: begin
        case (idx_q)
          3'd0:    red_d   = byte_i;
          3'd2:    green_d = byte_i;
          3'd4:    blue_d  = byte_i;
          3'd6:    alpha_d = byte_i;
          default: ;
        endcase
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + 3'd1;
        end else begin
          idx_d       = '0;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_PIXEL;
          res_o.red   = red_q;
          res_o.green = green_q;
          res_o.blue  = blue_q;
          res_o.alpha = alpha_q;
          if (col_last) begin
            res_o.row_end = 1'b1;
            col_d         = '0;
            if (row_last) begin
              res_o.image_end = 1'b1;
              row_d           = '0;
              phase_d         = PH_SIG;
              match_d         = 1'b1;
            end else begin
              row_d = row_q + DIM_BITS'(1);
            end
          end else begin
            col_d = col_q + DIM_BITS'(1);
          end
        end
      end
      default: begin
        if (byte_i != SIG_TEXT[idx_q]) begin
          match_d = 1'b0;
        end
        if (idx_q != LAST_IDX) begin
          idx_d = idx_q + 3'd1;
        end else begin
          idx_d = '0;
          if (match_q && byte_i == SIG_TEXT[idx_q]) begin
            phase_d = PH_DIMS;
          end else begin
            phase_d     = PH_SIG;
            match_d     = 1'b1;
            res_o.valid = 1'b1;
            res_o.kind  = KIND_BADSIG;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG;
      idx_q   <= '0;
      match_q <= 1'b1;
      col_q   <= '0;
      row_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      match_q <= match_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      dims_q   <= dims_d;
      width_q  <= width_d;
      height_q <= height_d;
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      alpha_q  <= alpha_d;
    end
  end

endmodule
